@@ rtl/ale_pkg.sv @@
package ale_pkg;

  localparam int CAPACITY = 16;

  typedef enum logic [3:0] {
    OP_APPEND    = 4'd0,
    OP_INSERT    = 4'd1,
    OP_OVERWRITE = 4'd2,
    OP_DELETE    = 4'd3,
    OP_FIND      = 4'd4,
    OP_MAX       = 4'd5,
    OP_MIN       = 4'd6,
    OP_SORT      = 4'd7,
    OP_REVERSE   = 4'd8,
    OP_READ      = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [3:0]         found_position;
    logic [4:0]         element_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHUP_RD,
    S_SHUP,
    S_SHDN_RD,
    S_SHDN,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_WR,
    S_SORT_HEAD,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_READ,
    S_DONE
  } state_t;

endpackage

@@ rtl/array_list_engine.sv @@
// Fixed-capacity list of signed 32-bit words held in one memory with one read port and
// one write port (read data registered). One transfer in yields one transfer out.
// Append and overwrite write the memory directly; read waits for the registered read data;
// find, delete, max and min walk the filled entries, one memory read per cycle; insert
// and delete shift entries one at a time; reverse swaps entries pairwise; insertion
// sort makes up to count*count/2 compares. A new item is taken only once the previous
// result has been handed over. Memory contents are undefined until written; only data
// read from filled entries is ever used.
module array_list_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ale_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ale_pkg::out_item_t   out_data
);

  localparam int CAPACITY = ale_pkg::CAPACITY;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  ale_pkg::state_t state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      jdx, jdx_next;
  logic [CW-1:0]      ilim, ilim_next;
  logic signed [31:0] hold, hold_next;
  logic signed [31:0] acc, acc_next;
  ale_pkg::in_item_t  req, req_next;
  ale_pkg::out_item_t res, res_next;
  logic               busy;
  logic               take;

  assign busy     = (state != ale_pkg::S_IDLE);
  assign in_ready = !busy && !out_valid;
  assign take     = in_valid && in_ready;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ale_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ale_pkg::S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    idx  <= idx_next;
    jdx  <= jdx_next;
    ilim <= ilim_next;
    hold <= hold_next;
    acc  <= acc_next;
    req  <= req_next;
    res  <= res_next;
  end

  function automatic logic [AW-1:0] ad(input logic [CW-1:0] x);
    return x[AW-1:0];
  endfunction

  always_comb begin
    logic [CW-1:0] pos;
    pos        = CW'(req.position);
    state_next = state;
    count_next = count;
    idx_next   = idx;
    jdx_next   = jdx;
    ilim_next  = ilim;
    hold_next  = hold;
    acc_next   = acc;
    req_next   = req;
    res_next   = res;
    raddr      = ad(idx);
    we         = 1'b0;
    waddr      = ad(idx);
    wdata      = req.value;
    case (state)
      ale_pkg::S_IDLE: begin
        if (take) begin
          req_next                = in_data;
          res_next.status         = ale_pkg::ST_OK;
          res_next.result_value   = '0;
          res_next.found_position = '0;
          state_next              = ale_pkg::S_DONE;
          idx_next                = '0;
          jdx_next                = '0;
          case (in_data.mode)
            ale_pkg::OP_APPEND: begin
              if (count >= CW'(CAPACITY)) begin
                res_next.status = ale_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = ad(count);
                wdata      = in_data.value;
                count_next = count + 1'b1;
              end
            end
            ale_pkg::OP_INSERT: begin
              if (count >= CW'(CAPACITY)) begin
                res_next.status = ale_pkg::ST_FULL;
              end else if ({1'b0, in_data.position} > (CW+1)'(count)) begin
                res_next.status = ale_pkg::ST_BADPOS;
              end else begin
                idx_next   = count;
                state_next = ale_pkg::S_SHUP_RD;
              end
            end
            ale_pkg::OP_OVERWRITE: begin
              if ({1'b0, in_data.position} >= (CW+1)'(count)) begin
                res_next.status = ale_pkg::ST_BADPOS;
              end else begin
                we    = 1'b1;
                waddr = in_data.position[AW-1:0];
                wdata = in_data.value;
              end
            end
            ale_pkg::OP_DELETE, ale_pkg::OP_FIND, ale_pkg::OP_MAX, ale_pkg::OP_MIN: begin
              if (count == '0) begin
                res_next.status = ale_pkg::ST_EMPTY;
              end else begin
                state_next = ale_pkg::S_SCAN_RD;
              end
            end
            ale_pkg::OP_SORT: begin
              if (count > CW'(1)) begin
                idx_next   = CW'(1);
                state_next = ale_pkg::S_SORT_RD;
              end
            end
            ale_pkg::OP_REVERSE: begin
              if (count > CW'(1)) begin
                jdx_next   = count - 1'b1;
                raddr      = '0;
                state_next = ale_pkg::S_REV_A;
              end
            end
            ale_pkg::OP_READ: begin
              if ({1'b0, in_data.position} >= (CW+1)'(count)) begin
                res_next.status = ale_pkg::ST_BADPOS;
              end else begin
                raddr      = in_data.position[AW-1:0];
                state_next = ale_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ale_pkg::S_READ: begin
        res_next.result_value = rdata;
        state_next            = ale_pkg::S_DONE;
      end
      ale_pkg::S_SCAN_RD: begin
        raddr      = ad(idx);
        idx_next   = idx + 1'b1;
        state_next = ale_pkg::S_SCAN;
      end
      ale_pkg::S_SCAN: begin
        // rdata holds entry idx-1
        raddr    = ad(idx);
        idx_next = idx + 1'b1;
        if (req.mode == ale_pkg::OP_MAX || req.mode == ale_pkg::OP_MIN) begin
          if (idx == CW'(1)) begin
            acc_next = rdata;
          end else if (req.mode == ale_pkg::OP_MAX ? (acc < rdata) : (rdata < acc)) begin
            acc_next = rdata;
          end
          if (idx == count) begin
            res_next.result_value = (idx == CW'(1)) ? rdata :
              ((req.mode == ale_pkg::OP_MAX ? (acc < rdata) : (rdata < acc)) ? rdata : acc);
            state_next = ale_pkg::S_DONE;
          end
        end else if (rdata == req.value) begin
          if (req.mode == ale_pkg::OP_FIND) begin
            res_next.found_position = 4'(idx - 1'b1);
            state_next              = ale_pkg::S_DONE;
          end else begin
            jdx_next   = idx - 1'b1;
            state_next = ale_pkg::S_SHDN_RD;
          end
        end else if (idx == count) begin
          res_next.status = ale_pkg::ST_NOTFOUND;
          state_next      = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_SHDN_RD: begin
        if (jdx + 1'b1 >= count) begin
          count_next = count - 1'b1;
          state_next = ale_pkg::S_DONE;
        end else begin
          raddr      = ad(jdx + 1'b1);
          state_next = ale_pkg::S_SHDN;
        end
      end
      ale_pkg::S_SHDN: begin
        we         = 1'b1;
        waddr      = ad(jdx);
        wdata      = rdata;
        jdx_next   = jdx + 1'b1;
        state_next = ale_pkg::S_SHDN_RD;
      end
      ale_pkg::S_SHUP_RD: begin
        if (idx <= pos) begin
          we         = 1'b1;
          waddr      = ad(pos);
          wdata      = req.value;
          count_next = count + 1'b1;
          state_next = ale_pkg::S_DONE;
        end else begin
          raddr      = ad(idx - 1'b1);
          state_next = ale_pkg::S_SHUP;
        end
      end
      ale_pkg::S_SHUP: begin
        we         = 1'b1;
        waddr      = ad(idx);
        wdata      = rdata;
        idx_next   = idx - 1'b1;
        state_next = ale_pkg::S_SHUP_RD;
      end
      ale_pkg::S_SORT_RD: begin
        // idx: outer index; jdx: slot of the hole; hold: key
        if (idx >= count) begin
          state_next = ale_pkg::S_DONE;
        end else begin
          raddr      = ad(idx);
          jdx_next   = idx;
          ilim_next  = '0;
          state_next = ale_pkg::S_SORT_CMP;
        end
      end
      ale_pkg::S_SORT_CMP: begin
        // first visit (ilim==0) latches key, then reads jdx-1
        if (ilim == '0) begin
          hold_next = rdata;
        end
        ilim_next  = CW'(1);
        raddr      = ad(jdx - 1'b1);
        state_next = ale_pkg::S_SORT_WR;
      end
      ale_pkg::S_SORT_WR: begin
        if (rdata > hold) begin
          we         = 1'b1;
          waddr      = ad(jdx);
          wdata      = rdata;
          jdx_next   = jdx - 1'b1;
          state_next = (jdx == CW'(1)) ? ale_pkg::S_SORT_HEAD : ale_pkg::S_SORT_CMP;
        end else begin
          we         = 1'b1;
          waddr      = ad(jdx);
          wdata      = hold;
          idx_next   = idx + 1'b1;
          state_next = ale_pkg::S_SORT_RD;
        end
      end
      ale_pkg::S_SORT_HEAD: begin
        // key lands in slot zero
        we         = 1'b1;
        waddr      = '0;
        wdata      = hold;
        idx_next   = idx + 1'b1;
        state_next = ale_pkg::S_SORT_RD;
      end
      ale_pkg::S_REV_A: begin
        hold_next  = rdata;
        raddr      = ad(jdx);
        state_next = ale_pkg::S_REV_B;
      end
      ale_pkg::S_REV_B: begin
        we         = 1'b1;
        waddr      = ad(idx);
        wdata      = rdata;
        state_next = ale_pkg::S_REV_C;
      end
      ale_pkg::S_REV_C: begin
        we       = 1'b1;
        waddr    = ad(jdx);
        wdata    = hold;
        idx_next = idx + 1'b1;
        jdx_next = jdx - 1'b1;
        if (idx + 1'b1 >= jdx - 1'b1) begin
          state_next = ale_pkg::S_DONE;
        end else begin
          raddr      = ad(idx + 1'b1);
          state_next = ale_pkg::S_REV_A;
        end
      end
      ale_pkg::S_DONE: begin
        res_next.element_count = count;
        state_next             = ale_pkg::S_IDLE;
      end
      default: state_next = ale_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("fill count beyond capacity");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    take |=> !out_valid) else $error("result before work");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ale_pkg::S_IDLE) && !take |=> $stable(count)) else $error("count drift");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CAP = ale_pkg::CAPACITY;

  class list_scoreboard;
    logic signed [31:0] words[CAP];
    int unsigned count;
    ale_pkg::out_item_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int first_hit(logic signed [31:0] v);
      for (int i = 0; i < count; i++) begin
        if (words[i] == v) return i;
      end
      return -1;
    endfunction

    function void note_item(ale_pkg::in_item_t it);
      ale_pkg::out_item_t r;
      int p;
      int hit;
      int i2;
      int j2;
      logic signed [31:0] t;
      r = '0;
      r.status = ale_pkg::ST_OK;
      p = it.position;
      case (it.mode)
        ale_pkg::OP_APPEND: begin
          if (count >= CAP) r.status = ale_pkg::ST_FULL;
          else begin
            words[count] = it.value;
            count++;
          end
        end
        ale_pkg::OP_INSERT: begin
          if (count >= CAP) r.status = ale_pkg::ST_FULL;
          else if (p > count) r.status = ale_pkg::ST_BADPOS;
          else begin
            for (int i = count; i > p; i--) words[i] = words[i-1];
            words[p] = it.value;
            count++;
          end
        end
        ale_pkg::OP_OVERWRITE: begin
          if (p >= count) r.status = ale_pkg::ST_BADPOS;
          else words[p] = it.value;
        end
        ale_pkg::OP_DELETE, ale_pkg::OP_FIND: begin
          if (count == 0) r.status = ale_pkg::ST_EMPTY;
          else begin
            hit = first_hit(it.value);
            if (hit < 0) r.status = ale_pkg::ST_NOTFOUND;
            else if (it.mode == ale_pkg::OP_FIND) r.found_position = hit[3:0];
            else begin
              for (int i = hit; i + 1 < count; i++) words[i] = words[i+1];
              count--;
            end
          end
        end
        ale_pkg::OP_MAX, ale_pkg::OP_MIN: begin
          if (count == 0) r.status = ale_pkg::ST_EMPTY;
          else begin
            t = words[0];
            for (int i = 1; i < count; i++) begin
              if (it.mode == ale_pkg::OP_MAX ? (words[i] > t) : (words[i] < t)) t = words[i];
            end
            r.result_value = t;
          end
        end
        ale_pkg::OP_SORT: begin
          for (int i = 1; i < count; i++) begin
            t = words[i];
            j2 = i;
            while (j2 > 0 && t < words[j2-1]) begin
              words[j2] = words[j2-1];
              j2--;
            end
            words[j2] = t;
          end
        end
        ale_pkg::OP_REVERSE: begin
          i2 = 0;
          j2 = int'(count) - 1;
          while (i2 < j2) begin
            t = words[i2];
            words[i2] = words[j2];
            words[j2] = t;
            i2++;
            j2--;
          end
        end
        ale_pkg::OP_READ: begin
          if (p >= count) r.status = ale_pkg::ST_BADPOS;
          else r.result_value = words[p];
        end
        default: ;
      endcase
      r.element_count = count[4:0];
      pending.push_back(r);
    endfunction

    task check_result(ale_pkg::out_item_t got);
      ale_pkg::out_item_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending", got, got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report("status", got, e);
      if (got.result_value !== e.result_value) report("result_value", got, e);
      if (got.found_position !== e.found_position) report("found_position", got, e);
      if (got.element_count !== e.element_count) report("element_count", got, e);
    endtask

    task report(string what, ale_pkg::out_item_t got, ale_pkg::out_item_t want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  ale_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  ale_pkg::out_item_t out_data;
  bit calm = 0;

  list_scoreboard board = new();

  array_list_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function bit lull();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  task automatic send(int m, int p, int v);
    ale_pkg::in_item_t it;
    it.mode = 4'(m);
    it.position = 5'(p);
    it.value = v;
    while (lull()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
  endtask

  function logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return $urandom;
      default: begin
        if (board.count > 0) return board.words[$urandom_range(board.count - 1)];
        return $signed($urandom_range(7)) - 3;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    out_ready <= rst ? 1'b0 : !lull();
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(ale_pkg::OP_DELETE, 0, 5);
    send(ale_pkg::OP_FIND, 0, 5);
    send(ale_pkg::OP_MAX, 0, 0);
    send(ale_pkg::OP_MIN, 0, 0);
    send(ale_pkg::OP_SORT, 0, 0);
    send(ale_pkg::OP_REVERSE, 0, 0);
    send(ale_pkg::OP_READ, 0, 0);
    send(ale_pkg::OP_OVERWRITE, 0, 1);
    send(ale_pkg::OP_INSERT, 1, 1);
    send(ale_pkg::OP_INSERT, 0, 32'sh7fff_ffff);
    send(ale_pkg::OP_APPEND, 0, 32'sh8000_0000);
    for (int i = 0; i < 14; i++) send(ale_pkg::OP_APPEND, 0, -1);
    send(ale_pkg::OP_APPEND, 0, 3);
    send(ale_pkg::OP_INSERT, 0, 3);
    send(ale_pkg::OP_READ, 16, 0);
    send(ale_pkg::OP_OVERWRITE, 31, 0);
    send(15, 31, -1);
    send(10, 0, 0);
    send(ale_pkg::OP_SORT, 0, 0);
    for (int n = 0; n < 900; n++) begin
      logic [3:0] m;
      calm = (n >= 300 && n < 420);
      m = ($urandom_range(29) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      if (board.count < 4 && $urandom_range(1)) m = ale_pkg::OP_APPEND;
      if (board.count > 13 && $urandom_range(1)) m = ale_pkg::OP_DELETE;
      send(m, $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(board.count)),
           pick_value());
    end
    in_valid <= 1'b0;
    calm = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ array_list_engine.f @@
rtl/ale_pkg.sv
rtl/array_list_engine.sv
tb/sv/tb.sv
